@@ design/cc2a_pkg.sv @@
`timescale 1ns / 1ps
// shared types, byte codes and helper functions for the console cell encoder
// no dependencies

package cc2a_pkg;

  localparam int COORD_W         = 16;
  localparam int DEF_COORD_BITS  = 16;
  localparam int DEF_QUEUE_DEPTH = 4;

  typedef struct packed {
    logic        kind;
    logic [7:0]  cell_attributes;
    logic [31:0] code_point;
    logic [15:0] row;
    logic [15:0] column;
    logic        force_move;
    logic        line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

  // sgr parts, in emission order
  localparam logic [1:0] PART_BOLD = 2'd0;
  localparam logic [1:0] PART_UND  = 2'd1;
  localparam logic [1:0] PART_FG   = 2'd2;
  localparam logic [1:0] PART_BG   = 2'd3;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FOUR  = 8'h34;

  // one classified item, handed from front to back
  typedef struct packed {
    logic                    is_move;
    logic [3:0]              chg;        // {bg, fg, underline, bold} changed
    logic                    bold;
    logic                    und;
    logic [2:0]              fg;
    logic [2:0]              bg;
    logic [1:0]              last_part;
    logic [1:0]              char_last;  // index of the last character byte
    logic [3:0][7:0]         char_bytes;
    logic [COORD_W-1:0]      row_val;
    logic [COORD_W-1:0]      col_val;
    logic [2:0]              row_ndig;
    logic [2:0]              col_ndig;
  } work_t;

  function automatic logic [16:0] pow10(input logic [2:0] pos);
    logic [16:0] p;
    case (pos)
      3'd0:    p = 17'd1;
      3'd1:    p = 17'd10;
      3'd2:    p = 17'd100;
      3'd3:    p = 17'd1000;
      3'd4:    p = 17'd10000;
      default: p = 17'd1;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] dec_len(input logic [COORD_W-1:0] v);
    logic [2:0] n;
    if (17'(v) >= 17'd10000)     n = 3'd5;
    else if (17'(v) >= 17'd1000) n = 3'd4;
    else if (17'(v) >= 17'd100)  n = 3'd3;
    else if (17'(v) >= 17'd10)   n = 3'd2;
    else                         n = 3'd1;
    return n;
  endfunction

endpackage

@@ design/cc2a_front.sv @@
`timescale 1ns / 1ps
// front end: accepts items, tracks attribute and cursor state, classifies
// each item into a work entry for the queue; uses cc2a_pkg

module cc2a_front #(
  parameter int COORD_BITS = cc2a_pkg::DEF_COORD_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cc2a_pkg::in_item_t  in_data,
  output logic                q_push,
  output cc2a_pkg::work_t     q_entry,
  input  logic                q_full
);
  import cc2a_pkg::*;

  logic                  bold_r, bold_nxt;
  logic                  und_r, und_nxt;
  logic [2:0]            fg_r, fg_nxt;
  logic [2:0]            bg_r, bg_nxt;
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic [COORD_BITS-1:0] col_r, col_nxt;

  logic                  accept;
  logic                  move_emit;
  logic [COORD_BITS-1:0] mv_row;
  logic [COORD_BITS-1:0] mv_col;
  logic                  a_bold;
  logic                  a_und;
  logic [2:0]            a_fg;
  logic [2:0]            a_bg;
  logic [3:0]            chg;
  logic [31:0]           cp;
  logic [3:0][7:0]       cbytes;
  logic [1:0]            clast;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign mv_row = in_data.row[COORD_BITS-1:0];
  assign mv_col = in_data.column[COORD_BITS-1:0];
  assign move_emit = in_data.force_move || (mv_row != row_r) || (mv_col != col_r);

  // attribute byte is BGR per nibble, colour index is RGB
  assign a_bold = in_data.cell_attributes[3];
  assign a_und  = in_data.cell_attributes[7];
  assign a_fg   = {in_data.cell_attributes[0], in_data.cell_attributes[1],
                   in_data.cell_attributes[2]};
  assign a_bg   = {in_data.cell_attributes[4], in_data.cell_attributes[5],
                   in_data.cell_attributes[6]};
  assign chg    = {a_bg != bg_r, a_fg != fg_r, a_und != und_r, a_bold != bold_r};

  assign cp = in_data.code_point;

  always_comb begin
    cbytes = '0;
    clast  = 2'd0;
    if (cp == 32'h0 || cp == 32'h20) begin
      cbytes[0] = CH_SPACE;
    end else if (cp == 32'h1B) begin
      cbytes[0] = CH_ESC;
      cbytes[1] = CH_ESC;
      clast     = 2'd1;
    end else if (cp < 32'h80) begin
      cbytes[0] = cp[7:0];
    end else if (cp < 32'h800) begin
      cbytes[0] = {3'b110, cp[10:6]};
      cbytes[1] = {2'b10, cp[5:0]};
      clast     = 2'd1;
    end else if (cp < 32'h10000) begin
      cbytes[0] = {4'b1110, cp[15:12]};
      cbytes[1] = {2'b10, cp[11:6]};
      cbytes[2] = {2'b10, cp[5:0]};
      clast     = 2'd2;
    end else if (cp <= 32'h10FFFF) begin
      cbytes[0] = {5'b11110, cp[20:18]};
      cbytes[1] = {2'b10, cp[17:12]};
      cbytes[2] = {2'b10, cp[11:6]};
      cbytes[3] = {2'b10, cp[5:0]};
      clast     = 2'd3;
    end else begin
      cbytes[0] = CH_QMARK;
    end
  end

  always_comb begin
    q_entry            = '0;
    q_entry.is_move    = in_data.kind;
    q_entry.chg        = in_data.kind ? 4'b0000 : chg;
    q_entry.bold       = a_bold;
    q_entry.und        = a_und;
    q_entry.fg         = a_fg;
    q_entry.bg         = a_bg;
    if (chg[3])      q_entry.last_part = PART_BG;
    else if (chg[2]) q_entry.last_part = PART_FG;
    else if (chg[1]) q_entry.last_part = PART_UND;
    else             q_entry.last_part = PART_BOLD;
    q_entry.char_last  = clast;
    q_entry.char_bytes = cbytes;
    q_entry.row_val    = COORD_W'(mv_row);
    q_entry.col_val    = COORD_W'(mv_col);
    q_entry.row_ndig   = dec_len(COORD_W'(mv_row));
    q_entry.col_ndig   = dec_len(COORD_W'(mv_col));
  end

  // an unchanged, unforced move produces nothing and is not queued
  assign q_push = accept && (!in_data.kind || move_emit);

  always_comb begin
    bold_nxt = bold_r;
    und_nxt  = und_r;
    fg_nxt   = fg_r;
    bg_nxt   = bg_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    if (accept) begin
      if (in_data.kind) begin
        if (move_emit) begin
          row_nxt = mv_row;
          col_nxt = mv_col;
        end
      end else begin
        bold_nxt = a_bold;
        und_nxt  = a_und;
        fg_nxt   = a_fg;
        bg_nxt   = a_bg;
        col_nxt  = col_r + COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bold_r <= 1'b0;
      und_r  <= 1'b0;
      fg_r   <= '0;
      bg_r   <= '0;
      row_r  <= '0;
      col_r  <= '0;
    end else begin
      bold_r <= bold_nxt;
      und_r  <= und_nxt;
      fg_r   <= fg_nxt;
      bg_r   <= bg_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

@@ design/cc2a_queue.sv @@
`timescale 1ns / 1ps
// small fifo of work entries between front and back
// uses cc2a_pkg for the entry type

module cc2a_queue #(
  parameter int DEPTH = cc2a_pkg::DEF_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cc2a_pkg::work_t  push_data,
  input  logic             pop,
  output cc2a_pkg::work_t  head,
  output logic             full,
  output logic             empty
);
  import cc2a_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop)      count_nxt = count_r + CNT_W'(1);
    else if (pop && !push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("queue fill count did not follow a lone write");

endmodule

@@ design/cc2a_back.sv @@
`timescale 1ns / 1ps
// back end: expands one work entry into escape, character and decimal bytes,
// one byte per cycle while out_stall is low, into an output register; uses cc2a_pkg

module cc2a_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cc2a_pkg::work_t      q_head,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cc2a_pkg::out_item_t  out_data
);
  import cc2a_pkg::*;

  localparam logic [3:0] P_IDLE = 4'd0;
  localparam logic [3:0] P_ESC  = 4'd1;
  localparam logic [3:0] P_LBR  = 4'd2;
  localparam logic [3:0] P_BOLD = 4'd3;
  localparam logic [3:0] P_UND  = 4'd4;
  localparam logic [3:0] P_FG   = 4'd5;
  localparam logic [3:0] P_BG   = 4'd6;
  localparam logic [3:0] P_CHAR = 4'd7;
  localparam logic [3:0] P_ROW  = 4'd8;
  localparam logic [3:0] P_SEMI = 4'd9;
  localparam logic [3:0] P_COL  = 4'd10;
  localparam logic [3:0] P_H    = 4'd11;

  function automatic logic [3:0] first_part(input logic [3:0] m);
    logic [3:0] p;
    if (m[0])      p = P_BOLD;
    else if (m[1]) p = P_UND;
    else if (m[2]) p = P_FG;
    else if (m[3]) p = P_BG;
    else           p = P_CHAR;
    return p;
  endfunction

  logic [3:0]  phase_r, phase_nxt;
  logic [1:0]  sub_r, sub_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [16:0] rem_r, rem_nxt;
  work_t       cur_r;

  logic        out_valid_r;
  out_item_t   out_data_r;

  logic        advance;
  logic        emit;
  logic        done;
  logic [7:0]  byte_v;

  logic [1:0]  part_idx;
  logic        two_char;
  logic [7:0]  c0;
  logic [7:0]  c1;
  logic        part_end;
  logic [16:0] p10;
  logic [3:0]  digit;

  assign advance = !out_valid_r || !out_stall;

  assign part_idx = 2'(phase_r - P_BOLD);

  // text of the current sgr part
  always_comb begin
    two_char = 1'b0;
    c0       = CH_TWO;
    c1       = CH_TWO;
    case (part_idx)
      PART_BOLD: begin
        two_char = cur_r.bold;
        c0       = cur_r.bold ? CH_ONE : CH_TWO;
        c1       = CH_TWO;
      end
      PART_UND: begin
        two_char = cur_r.und;
        c0       = cur_r.und ? CH_FOUR : CH_TWO;
        c1       = CH_FOUR;
      end
      PART_FG: begin
        c0 = CH_THREE;
        c1 = {5'b00110, cur_r.fg};
      end
      default: begin
        c0 = CH_FOUR;
        c1 = {5'b00110, cur_r.bg};
      end
    endcase
  end

  assign part_end = two_char ? (sub_r == 2'd1) : (sub_r == 2'd2);

  // one decimal digit per cycle while the output is not stalled, most significant first
  assign p10 = pow10(pos_r);
  always_comb begin
    digit = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (rem_r >= 17'(i) * p10) digit = 4'(i);
    end
  end

  always_comb begin
    byte_v    = CH_ESC;
    emit      = 1'b1;
    done      = 1'b0;
    phase_nxt = phase_r;
    sub_nxt   = sub_r;
    pos_nxt   = pos_r;
    rem_nxt   = rem_r;
    unique case (phase_r) inside
      P_IDLE: begin
        emit = 1'b0;
      end
      P_ESC: begin
        byte_v    = CH_ESC;
        phase_nxt = P_LBR;
      end
      P_LBR: begin
        byte_v    = CH_LBR;
        phase_nxt = cur_r.is_move ? P_ROW : first_part(cur_r.chg);
      end
      P_BOLD, P_UND, P_FG, P_BG: begin
        if (part_end) begin
          // the closing separator of the last listed part ends the sequence
          byte_v    = (part_idx == cur_r.last_part) ? CH_M : CH_SEMI;
          sub_nxt   = 2'd0;
          phase_nxt = first_part(cur_r.chg & (4'b1110 << part_idx));
        end else begin
          byte_v  = (sub_r == 2'd0) ? c0 : c1;
          sub_nxt = sub_r + 2'd1;
        end
      end
      P_CHAR: begin
        byte_v = cur_r.char_bytes[sub_r];
        if (sub_r == cur_r.char_last) begin
          done = 1'b1;
        end else begin
          sub_nxt = sub_r + 2'd1;
        end
      end
      P_ROW, P_COL: begin
        byte_v  = CH_ZERO + 8'(digit);
        rem_nxt = rem_r - 17'(digit) * p10;
        if (pos_r == 3'd0) begin
          phase_nxt = (phase_r == P_ROW) ? P_SEMI : P_H;
        end else begin
          pos_nxt = pos_r - 3'd1;
        end
      end
      P_SEMI: begin
        byte_v    = CH_SEMI;
        rem_nxt   = 17'(cur_r.col_val);
        pos_nxt   = cur_r.col_ndig - 3'd1;
        phase_nxt = P_COL;
      end
      P_H: begin
        byte_v = CH_H;
        done   = 1'b1;
      end
      default: begin
        emit      = 1'b0;
        phase_nxt = P_IDLE;
      end
    endcase
    if (done) phase_nxt = P_IDLE;
  end

  // the next entry is taken on the cycle that ends the current one
  assign q_pop = advance && ((phase_r == P_IDLE) || done) && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      sub_r   <= 2'd0;
      pos_r   <= 3'd0;
      rem_r   <= '0;
    end else if (advance) begin
      if (q_pop) begin
        phase_r <= (q_head.is_move || (q_head.chg != 4'b0000)) ? P_ESC : P_CHAR;
        sub_r   <= 2'd0;
        pos_r   <= q_head.row_ndig - 3'd1;
        rem_r   <= 17'(q_head.row_val);
      end else begin
        phase_r <= phase_nxt;
        sub_r   <= sub_nxt;
        pos_r   <= pos_nxt;
        rem_r   <= rem_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data_r.out_byte  <= byte_v;
      out_data_r.last_byte <= done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == P_ROW || phase_r == P_COL) |-> rem_r < 17'(10) * pow10(pos_r))
    else $error("decimal remainder exceeds its digit position");

  a_char_index: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == P_CHAR) |-> sub_r <= cur_r.char_last)
    else $error("character byte index past the encoded length");

endmodule

@@ design/console_cell_to_ansi_utf8.sv @@
`timescale 1ns / 1ps
// top level of the console cell to ansi/utf-8 encoder
// instantiates cc2a_front, cc2a_queue and cc2a_back; uses cc2a_pkg

// Turns screen cells and cursor moves into a terminal byte stream. The front
// end takes one item per cycle while the work queue (QUEUE_DEPTH entries) has
// room; an unchanged, unforced cursor move is absorbed there and produces no
// bytes. The back end emits one byte per cycle while it has entries and
// out_stall is low; an item yields 1 to 4 bytes for a plain cell, up to 18
// for a cell that also changes all attributes and up to 14 for a cursor move.
// The last byte of every item is flagged with last_byte. Row and column are
// taken modulo 2^COORD_BITS, and each cell advances the stored column with
// the same wrap.

module console_cell_to_ansi_utf8 #(
  parameter int COORD_BITS  = cc2a_pkg::DEF_COORD_BITS,
  parameter int QUEUE_DEPTH = cc2a_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cc2a_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cc2a_pkg::out_item_t  out_data
);
  import cc2a_pkg::*;

  logic   q_push;
  work_t  q_entry;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;
  work_t  q_head;

  cc2a_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_entry  (q_entry),
    .q_full   (q_full)
  );

  cc2a_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_entry),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  cc2a_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ tb/sv/tb_console_cell_to_ansi_utf8.sv @@
`timescale 1ns / 1ps
// testbench for console_cell_to_ansi_utf8: directed and random cells and cursor moves,
// each transfer checked against a built-in model of the terminal byte stream
// depends on cc2a_pkg and the console_cell_to_ansi_utf8 rtl

module tb_console_cell_to_ansi_utf8;
  import cc2a_pkg::*;

  localparam logic KIND_CELL = 1'b0;
  localparam logic KIND_MOVE = 1'b1;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // terminal state as the model sees it
  logic       term_bold;
  logic       term_und;
  logic [2:0] term_fg;
  logic [2:0] term_bg;
  logic [15:0] term_row;
  logic [15:0] term_col;

  logic [7:0] item_bytes[$];
  out_item_t  expected_bytes[$];
  int         mismatch_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  logic [7:0] held_attr = 8'h00;

  console_cell_to_ansi_utf8 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_decimal(input logic [15:0] v);
    int unsigned x;
    logic [7:0]  digit [0:4];
    int          k;
    x = 32'(v);
    k = 0;
    do begin
      digit[k] = CH_ZERO + 8'(x % 10);
      x = x / 10;
      k++;
    end while (x != 0);
    for (int i = k - 1; i >= 0; i--) item_bytes.push_back(digit[i]);
  endfunction

  // console colour bits are bgr, ansi index is rgb
  function automatic logic [2:0] ansi_colour(input logic [2:0] bits);
    return {bits[0], bits[1], bits[2]};
  endfunction

  function automatic void predict_terminal_bytes(input in_item_t it);
    logic        bold;
    logic        und;
    logic [2:0]  fg;
    logic [2:0]  bg;
    logic [31:0] cp;
    out_item_t   ob;
    item_bytes.delete();
    if (it.kind == KIND_MOVE) begin
      if (it.force_move || it.row != term_row || it.column != term_col) begin
        item_bytes.push_back(CH_ESC);
        item_bytes.push_back(CH_LBR);
        add_decimal(it.row);
        item_bytes.push_back(CH_SEMI);
        add_decimal(it.column);
        item_bytes.push_back(CH_H);
        term_row = it.row;
        term_col = it.column;
      end
    end else begin
      bold = it.cell_attributes[3];
      und  = it.cell_attributes[7];
      fg   = ansi_colour(it.cell_attributes[2:0]);
      bg   = ansi_colour(it.cell_attributes[6:4]);
      cp   = it.code_point;
      if (bold != term_bold || und != term_und || fg != term_fg || bg != term_bg) begin
        item_bytes.push_back(CH_ESC);
        item_bytes.push_back(CH_LBR);
        if (bold != term_bold) begin
          if (bold) begin
            item_bytes.push_back(CH_ONE);
          end else begin
            item_bytes.push_back(CH_TWO);
            item_bytes.push_back(CH_TWO);
          end
          item_bytes.push_back(CH_SEMI);
        end
        if (und != term_und) begin
          if (und) begin
            item_bytes.push_back(CH_FOUR);
          end else begin
            item_bytes.push_back(CH_TWO);
            item_bytes.push_back(CH_FOUR);
          end
          item_bytes.push_back(CH_SEMI);
        end
        if (fg != term_fg) begin
          item_bytes.push_back(CH_THREE);
          item_bytes.push_back(CH_ZERO + 8'(fg));
          item_bytes.push_back(CH_SEMI);
        end
        if (bg != term_bg) begin
          item_bytes.push_back(CH_FOUR);
          item_bytes.push_back(CH_ZERO + 8'(bg));
          item_bytes.push_back(CH_SEMI);
        end
        // trailing separator becomes the sgr terminator
        item_bytes[item_bytes.size() - 1] = CH_M;
        term_bold = bold;
        term_und  = und;
        term_fg   = fg;
        term_bg   = bg;
      end
      if (cp == 32'h0 || cp == 32'h20) begin
        item_bytes.push_back(CH_SPACE);
      end else if (cp == 32'h1B) begin
        item_bytes.push_back(CH_ESC);
        item_bytes.push_back(CH_ESC);
      end else if (cp < 32'h80) begin
        item_bytes.push_back(cp[7:0]);
      end else if (cp < 32'h800) begin
        item_bytes.push_back({3'b110, cp[10:6]});
        item_bytes.push_back({2'b10, cp[5:0]});
      end else if (cp < 32'h10000) begin
        item_bytes.push_back({4'b1110, cp[15:12]});
        item_bytes.push_back({2'b10, cp[11:6]});
        item_bytes.push_back({2'b10, cp[5:0]});
      end else if (cp <= 32'h10FFFF) begin
        item_bytes.push_back({5'b11110, cp[20:18]});
        item_bytes.push_back({2'b10, cp[17:12]});
        item_bytes.push_back({2'b10, cp[11:6]});
        item_bytes.push_back({2'b10, cp[5:0]});
      end else begin
        item_bytes.push_back(CH_QMARK);
      end
      term_col = term_col + 16'd1;
    end
    foreach (item_bytes[i]) begin
      ob.out_byte  = item_bytes[i];
      ob.last_byte = (i == item_bytes.size() - 1);
      expected_bytes.push_back(ob);
    end
  endfunction

  function automatic in_item_t cell_item(input logic [7:0] attr, input logic [31:0] cp,
                                         input logic line_end);
    in_item_t it;
    it.kind            = KIND_CELL;
    it.cell_attributes = attr;
    it.code_point      = cp;
    it.row             = 16'($urandom());
    it.column          = 16'($urandom());
    it.force_move      = 1'($urandom());
    it.line_end        = line_end;
    return it;
  endfunction

  function automatic in_item_t move_item(input logic [15:0] row, input logic [15:0] col,
                                         input logic force_move);
    in_item_t it;
    it.kind            = KIND_MOVE;
    it.cell_attributes = 8'($urandom());
    it.code_point      = $urandom();
    it.row             = row;
    it.column          = col;
    it.force_move      = force_move;
    it.line_end        = 1'($urandom());
    return it;
  endfunction

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predict_terminal_bytes(it);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected transfer: out_byte %h last_byte %b",
                 out_data.out_byte, out_data.last_byte);
          mismatch_count++;
        end else begin
          if (out_data.out_byte !== expected_bytes[0].out_byte) begin
            $error("out_byte: expected %h actual %h",
                   expected_bytes[0].out_byte, out_data.out_byte);
            mismatch_count++;
          end
          if (out_data.last_byte !== expected_bytes[0].last_byte) begin
            $error("last_byte: expected %b actual %b",
                   expected_bytes[0].last_byte, out_data.last_byte);
            mismatch_count++;
          end
          void'(expected_bytes.pop_front());
        end
      end
      out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  task automatic test_char_encoding();
    logic [31:0] cps[$];
    cps = '{32'h0, 32'h20, 32'h1B, 32'h41, 32'h7F, 32'h7FF, 32'h800, 32'hD800,
            32'h10000, 32'h10FFFF, 32'h110000, 32'hFFFFFFFF};
    foreach (cps[i]) send_item(cell_item(8'h00, cps[i], 1'b0));
  endtask

  task automatic test_attributes();
    // all parts set, then all cleared: the longest sgr burst
    send_item(cell_item(8'hFF, 32'h10FFFF, 1'b0));
    send_item(cell_item(8'h00, 32'h10000, 1'b0));
    send_item(cell_item(8'h08, 32'h61, 1'b0));
    send_item(cell_item(8'h80, 32'h62, 1'b0));
    send_item(cell_item(8'h81, 32'h63, 1'b0));
    send_item(cell_item(8'h42, 32'h64, 1'b0));
    send_item(cell_item(8'h42, 32'h65, 1'b1));
    held_attr = 8'h42;
  endtask

  task automatic test_cursor_moves();
    send_item(move_item(16'hFFFF, 16'hFFFF, 1'b0));
    send_item(move_item(16'hFFFF, 16'hFFFF, 1'b0));
    send_item(move_item(16'hFFFF, 16'hFFFF, 1'b1));
    // column wraps to zero, so this move is unchanged
    send_item(cell_item(held_attr, 32'h5A, 1'b1));
    send_item(move_item(16'hFFFF, 16'h0000, 1'b0));
    send_item(move_item(16'd0, 16'd0, 1'b0));
    send_item(move_item(16'd10000, 16'd9, 1'b1));
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(4, 0))
      0:       return 16'($urandom_range(9, 0));
      1:       return 16'($urandom_range(99, 10));
      2:       return 16'($urandom_range(999, 100));
      3:       return 16'($urandom_range(9999, 1000));
      default: return 16'($urandom_range(65535, 10000));
    endcase
  endfunction

  function automatic logic [31:0] rand_code_point();
    case ($urandom_range(9, 0))
      0:       return $urandom_range(32'h7F, 32'h0);
      1: begin
        case ($urandom_range(2, 0))
          0:       return 32'h0;
          1:       return 32'h20;
          default: return 32'h1B;
        endcase
      end
      2:       return $urandom_range(32'h7FF, 32'h80);
      3:       return $urandom_range(32'hFFFF, 32'h800);
      4:       return $urandom_range(32'hDFFF, 32'hD800);
      5:       return $urandom_range(32'h10FFFF, 32'h10000);
      6:       return $urandom_range(32'hFFFFFFFF, 32'h110000);
      7:       return $urandom();
      default: return $urandom_range(32'h7E, 32'h21);
    endcase
  endfunction

  // mostly line runs (a move, then cells with line_end on the last), some loose items
  task automatic test_random_stream(input int count);
    int       sent;
    int       run_len;
    in_item_t it;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99, 0) < 85) begin
        if ($urandom_range(99, 0) < 20)
          send_item(move_item(term_row, term_col, 1'($urandom())));
        else
          send_item(move_item(rand_coord(), rand_coord(), 1'($urandom())));
        sent++;
        run_len = $urandom_range(8, 1);
        for (int i = 0; i < run_len; i++) begin
          if ($urandom_range(99, 0) < 30) held_attr = 8'($urandom());
          send_item(cell_item(held_attr, rand_code_point(), i == run_len - 1));
          sent++;
        end
      end else begin
        it = '{kind: 1'($urandom()), cell_attributes: 8'($urandom()),
               code_point: rand_code_point(), row: 16'($urandom()),
               column: 16'($urandom()), force_move: 1'($urandom()),
               line_end: 1'($urandom())};
        send_item(it);
        sent++;
      end
    end
  endtask

  initial begin
    term_bold = 1'b0;
    term_und  = 1'b0;
    term_fg   = 3'd0;
    term_bg   = 3'd0;
    term_row  = 16'd0;
    term_col  = 16'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 33;
    recv_stall_pct = 79;
    test_char_encoding();
    test_attributes();
    test_cursor_moves();
    test_random_stream(115);

    send_idle_pct  = 79;
    recv_stall_pct = 33;
    test_random_stream(115);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_stream(115);

    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    // catch any stray bytes after the last expected one
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_console_cell_to_ansi_utf8: clean");
    else
      $display("tb_console_cell_to_ansi_utf8: errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_console_cell_to_ansi_utf8: errors");
    $finish;
  end

endmodule
